FILE: rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue insert core.
`default_nettype none
package spq_pkg;

	localparam int DATA_W       = 32;
	localparam int CAPACITY_DEF = 16;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_DUMP   = 1'b1;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_ENTRY    = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic                     mode;
		logic signed [DATA_W-1:0] item_value;
		logic signed [DATA_W-1:0] item_priority;
	} cmd_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] out_value;
		logic signed [DATA_W-1:0] out_priority;
		logic                     last;
	} result_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

endpackage
`default_nettype wire

FILE: rtl/sorted_priority_queue_insert_core.sv
// Sorted priority queue top level: request sequencer around the entry store.
//
// Holds up to CAPACITY (value, priority) entries in ascending priority order in a
// single memory with registered read data; equal priorities leave first in, first
// out. A request is taken when start is high and busy is low. An insert walks the
// store from the back, moving each larger entry up one slot per cycle, and gives one
// result; an insert into an empty store writes its entry without a walk, and a full
// store drops it with a full status. A dump reads one entry per cycle and gives n
// results (one empty status if n is zero). Each result is shown for exactly one
// cycle with strobe high; the receiver cannot stall it.
`default_nettype none
module sorted_priority_queue_insert_core #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire spq_pkg::cmd_t    cmd,
	output logic                  strobe,
	output spq_pkg::result_t      result
);
	import spq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INS  = 2'd1;
	localparam logic [1:0] S_PUT  = 2'd2;
	localparam logic [1:0] S_DUMP = 2'd3;

	logic [1:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] addr_q, addr_d;
	entry_t        new_q, new_d;
	logic          strobe_q, strobe_d;
	result_t       result_q, result_d;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;
	logic [CW-1:0] count_m1;
	logic          is_last;

	spq_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign count_m1 = count_q - CW'(1);
	assign is_last  = (CW'(addr_q) == count_m1);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		addr_d   = addr_q;
		new_d    = new_q;
		we       = 1'b0;
		waddr    = '0;
		wdata    = new_q;
		re       = 1'b0;
		raddr    = '0;
		strobe_d = 1'b0;
		result_d = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					new_d.value = cmd.item_value;
					new_d.prio  = cmd.item_priority;
					if (cmd.mode == MODE_INSERT) begin
						if (count_q == CAP_W) begin
							strobe_d        = 1'b1;
							result_d.status = ST_FULL;
							result_d.last   = 1'b1;
						end else if (count_q == '0) begin
							we              = 1'b1;
							wdata.value     = cmd.item_value;
							wdata.prio      = cmd.item_priority;
							count_d         = count_q + CW'(1);
							strobe_d        = 1'b1;
							result_d.status = ST_INSERTED;
							result_d.last   = 1'b1;
						end else begin
							re      = 1'b1;
							raddr   = count_m1[AW-1:0];
							addr_d  = count_m1[AW-1:0];
							state_d = S_INS;
						end
					end else begin
						if (count_q == '0) begin
							strobe_d        = 1'b1;
							result_d.status = ST_EMPTY;
							result_d.last   = 1'b1;
						end else begin
							re      = 1'b1;
							addr_d  = '0;
							state_d = S_DUMP;
						end
					end
				end
			end
			S_INS: begin
				we    = 1'b1;
				waddr = addr_q + AW'(1);
				if (rdata.prio > new_q.prio) begin
					wdata = rdata;
					if (addr_q == '0) begin
						state_d = S_PUT;
					end else begin
						re     = 1'b1;
						raddr  = addr_q - AW'(1);
						addr_d = addr_q - AW'(1);
					end
				end else begin
					count_d         = count_q + CW'(1);
					strobe_d        = 1'b1;
					result_d.status = ST_INSERTED;
					result_d.last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_PUT: begin
				we              = 1'b1;
				count_d         = count_q + CW'(1);
				strobe_d        = 1'b1;
				result_d.status = ST_INSERTED;
				result_d.last   = 1'b1;
				state_d         = S_IDLE;
			end
			S_DUMP: begin
				strobe_d              = 1'b1;
				result_d.status       = ST_ENTRY;
				result_d.out_value    = rdata.value;
				result_d.out_priority = rdata.prio;
				result_d.last         = is_last;
				if (is_last) begin
					state_d = S_IDLE;
				end else begin
					re     = 1'b1;
					raddr  = addr_q + AW'(1);
					addr_d = addr_q + AW'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			addr_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			addr_q   <= addr_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		new_q    <= new_d;
		result_q <= result_d;
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_W)
		else $error("entry count above capacity");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && result_q.status == ST_FULL) |-> (count_q == CAP_W))
		else $error("full status with free slots");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && result_q.status == ST_INSERTED) |->
			(count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow count by one");

	a_dump_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |=> (strobe_q && result_q.status == ST_ENTRY))
		else $error("dump cycle without entry result");
`endif

endmodule
`default_nettype wire

FILE: rtl/spq_mem.sv
// Entry store: one write port, one read port with registered read data.
`default_nettype none
module spq_mem #(
	parameter int DEPTH = spq_pkg::CAPACITY_DEF,
	parameter int AW    = 4
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire spq_pkg::entry_t wdata,
	input  wire logic            re,
	input  wire logic [AW-1:0]   raddr,
	output spq_pkg::entry_t      rdata
);
	import spq_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: tb/sv/tb_sorted_priority_queue_insert_core.sv
// Self-checking testbench for the sorted priority queue insert core.
`default_nettype none
module tb_sorted_priority_queue_insert_core;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	typedef logic signed [DATA_W-1:0] word_t;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    cmd    = '0;
	logic    busy;
	logic    strobe;
	result_t result;

	word_t   shadow_values[$];
	word_t   shadow_prios[$];
	result_t expected_results[$];
	int      error_count = 0;
	int      idle_pct    = 11;

	sorted_priority_queue_insert_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.strobe (strobe),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic cmd_t make_cmd(input logic mode, input word_t value, input word_t prio);
		cmd_t c;
		c.mode          = mode;
		c.item_value    = value;
		c.item_priority = prio;
		return c;
	endfunction

	function automatic word_t pick_priority();
		int sel;
		sel = $urandom_range(99);
		if (sel < 45) begin
			return word_t'($urandom_range(6)) - 3;
		end else if (sel < 60) begin
			case ($urandom_range(3))
				0: return {1'b1, {(DATA_W-1){1'b0}}};
				1: return {1'b0, {(DATA_W-1){1'b1}}};
				2: return '0;
				default: return '1;
			endcase
		end
		return word_t'($urandom);
	endfunction

	task automatic predict_response(input cmd_t c);
		result_t r;
		int      pos;
		r      = '0;
		r.last = 1'b1;
		if (c.mode == MODE_INSERT) begin
			if (shadow_values.size() >= CAPACITY_DEF) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < shadow_prios.size() &&
				       $signed(shadow_prios[pos]) <= $signed(c.item_priority))
					pos++;
				shadow_values.insert(pos, c.item_value);
				shadow_prios.insert(pos, c.item_priority);
				r.status = ST_INSERTED;
			end
			expected_results.push_back(r);
		end else if (shadow_values.size() == 0) begin
			r.status = ST_EMPTY;
			expected_results.push_back(r);
		end else begin
			for (int i = 0; i < shadow_values.size(); i++) begin
				r.status       = ST_ENTRY;
				r.out_value    = shadow_values[i];
				r.out_priority = shadow_prios[i];
				r.last         = (i == shadow_values.size() - 1);
				expected_results.push_back(r);
			end
		end
	endtask

	// hold start across back-to-back requests; lower it only for an idle gap
	task automatic send_request(input cmd_t c);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		predict_response(c);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d value %0d priority %0d last %0d",
				       result.status, result.out_value, result.out_priority, result.last);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					error_count++;
				end
				if (result.out_value !== want.out_value) begin
					$error("out_value: expected %0d, got %0d", want.out_value,
					       result.out_value);
					error_count++;
				end
				if (result.out_priority !== want.out_priority) begin
					$error("out_priority: expected %0d, got %0d", want.out_priority,
					       result.out_priority);
					error_count++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result.last);
					error_count++;
				end
			end
		end
	end

	task automatic test_dump_empty();
		send_request(make_cmd(MODE_DUMP, word_t'($urandom), word_t'($urandom)));
	endtask

	task automatic test_insert_extremes();
		send_request(make_cmd(MODE_INSERT, {1'b0, {(DATA_W-1){1'b1}}}, 5));
		send_request(make_cmd(MODE_INSERT, {1'b1, {(DATA_W-1){1'b0}}}, 5));
		send_request(make_cmd(MODE_INSERT, '0, 5));
		send_request(make_cmd(MODE_INSERT, '1, {1'b0, {(DATA_W-1){1'b1}}}));
		send_request(make_cmd(MODE_INSERT, 1, {1'b1, {(DATA_W-1){1'b0}}}));
		send_request(make_cmd(MODE_INSERT, 32'h5555_5555, '0));
		send_request(make_cmd(MODE_INSERT, 32'haaaa_aaaa, '1));
		send_request(make_cmd(MODE_DUMP, '0, '0));
		send_request(make_cmd(MODE_INSERT, 2, 5));
		send_request(make_cmd(MODE_DUMP, '1, '1));
	endtask

	task automatic test_random_traffic(input int count);
		for (int i = 0; i < count; i++) begin
			idle_pct = (i >= count / 3 && i < 2 * count / 3) ? 0 : 11;
			if ($urandom_range(99) < 20)
				send_request(make_cmd(MODE_DUMP, word_t'($urandom), word_t'($urandom)));
			else
				send_request(make_cmd(MODE_INSERT, word_t'($urandom), pick_priority()));
		end
		idle_pct = 11;
	endtask

	task automatic test_full_store();
		while (shadow_values.size() < CAPACITY_DEF)
			send_request(make_cmd(MODE_INSERT, word_t'($urandom), pick_priority()));
		send_request(make_cmd(MODE_INSERT, {1'b1, {(DATA_W-1){1'b0}}},
		                      {1'b1, {(DATA_W-1){1'b0}}}));
		send_request(make_cmd(MODE_INSERT, {1'b0, {(DATA_W-1){1'b1}}},
		                      {1'b0, {(DATA_W-1){1'b1}}}));
		send_request(make_cmd(MODE_DUMP, '0, '0));
	endtask

	task automatic drain_results();
		int waited;
		waited = 0;
		while (expected_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_dump_empty();
		test_insert_extremes();
		test_random_traffic(440);
		test_full_store();
		start <= 1'b0;

		drain_results();
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
